@@ sv/itoa_pkg.sv @@
package itoa_pkg;

  // Width of the converted value and the sizes derived from it
  localparam int VALUE_WIDTH = 32;
  // Enough BCD digits for magnitudes up to 2^(VALUE_WIDTH-1); also covers all hex nibbles
  localparam int NUM_DIGITS  = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int DIGIT_BITS  = NUM_DIGITS * 4;
  localparam int ITER_W      = $clog2(VALUE_WIDTH + 1);
  localparam int CNT_W       = $clog2(NUM_DIGITS + 1);

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [3:0] DIGIT_TEN    = 4'd10;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          hex_mode;
    logic                          upper_case;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } itoa_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_digit;
    logic emit_sign;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic conv_last;
    logic top_zero;
    logic remain_one;
    logic neg_dec;
  } dp_status_t;

  // One digit value (0..15) to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    if (d < DIGIT_TEN) begin
      digit_char = CHAR_ZERO + {4'b0000, d};
    end else begin
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      digit_char = base + {4'b0000, d - DIGIT_TEN};
    end
  endfunction

endpackage

@@ sv/integer_to_ascii_digits.sv @@
// Converts a signed two's-complement value to ASCII decimal or hex digits, most
// significant first, one character per output transaction, with last set on the
// final one. Decimal negatives get a leading '-'; hex negatives print the
// magnitude unsigned; the most negative value prints as 2^(W-1); zero gives '0'.
// One value is handled at a time. After the value is accepted, decimal runs a
// shift-add-3 binary-to-BCD conversion over the W bits (W = value width) and
// hex holds the loaded digits through the same conversion state; then leading
// zero digits (up to 3*W/10) are dropped one at a time and a last step ends the
// scan; then the characters are sent while the output is ready. The input is
// ready again the cycle after the last character is taken.
module integer_to_ascii_digits (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  itoa_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output itoa_pkg::out_item_t out_data_o
);
  import itoa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  itoa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Magnitude, BCD conversion and digit shifting
  itoa_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

@@ sv/itoa_dpath.sv @@
module itoa_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itoa_pkg::ctrl_cmd_t cmd_i,
  input  itoa_pkg::in_item_t  in_data_i,
  output itoa_pkg::dp_status_t status_o,
  output itoa_pkg::out_item_t out_data_o
);
  import itoa_pkg::*;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [DIGIT_BITS-1:0]  bcd_q, bcd_d;
  logic [DIGIT_BITS-1:0]  bcd_adj;
  logic [ITER_W-1:0]      iter_q, iter_d;
  logic [CNT_W-1:0]       remain_q, remain_d;
  logic                   neg_dec_q, neg_dec_d;
  logic                   hex_q, hex_d;
  logic                   upper_q, upper_d;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic [3:0]             top_digit;

  // Magnitude of the incoming value; the most negative value wraps to 2^(W-1)
  assign in_neg = in_data_i.value[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~in_data_i.value + 1'b1) : in_data_i.value;

  // Add-3 correction on every BCD digit ahead of the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // Next-state of the datapath registers
  always_comb begin
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    iter_d    = iter_q;
    remain_d  = remain_q;
    neg_dec_d = neg_dec_q;
    hex_d     = hex_q;
    upper_d   = upper_q;
    if (cmd_i.load) begin
      hex_d     = in_data_i.hex_mode;
      upper_d   = in_data_i.upper_case;
      neg_dec_d = in_neg & ~in_data_i.hex_mode;
      remain_d  = CNT_W'(NUM_DIGITS);
      iter_d    = ITER_W'(VALUE_WIDTH);
      bin_d     = in_mag;
      if (in_data_i.hex_mode) begin
        bcd_d = {{(DIGIT_BITS-VALUE_WIDTH){1'b0}}, in_mag};
      end else begin
        bcd_d = '0;
      end
    end else if (cmd_i.dabble) begin
      // hex digits are already in place; only the iteration count runs
      if (!hex_q) begin
        bcd_d = {bcd_adj[DIGIT_BITS-2:0], bin_q[VALUE_WIDTH-1]};
        bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      end
      iter_d = iter_q - 1'b1;
    end else if (cmd_i.shift_digit) begin
      bcd_d    = {bcd_q[DIGIT_BITS-5:0], 4'b0000};
      remain_d = remain_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q   <= '0;
      remain_q <= '0;
    end else begin
      iter_q   <= iter_d;
      remain_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    neg_dec_q <= neg_dec_d;
    hex_q     <= hex_d;
    upper_q   <= upper_d;
  end

  // Status back to the controller
  assign top_digit           = bcd_q[DIGIT_BITS-1 -: 4];
  assign status_o.conv_last  = (iter_q == ITER_W'(1));
  assign status_o.top_zero   = (top_digit == 4'd0);
  assign status_o.remain_one = (remain_q == CNT_W'(1));
  assign status_o.neg_dec    = neg_dec_q;

  // Output character: sign or the leading remaining digit
  assign out_data_o.character = cmd_i.emit_sign ? CHAR_MINUS
                              : digit_char(top_digit, upper_q & hex_q);
  assign out_data_o.last      = ~cmd_i.emit_sign & (remain_q == CNT_W'(1));

endmodule

@@ sv/itoa_ctrl.sv @@
module itoa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  itoa_pkg::dp_status_t status_i,
  output itoa_pkg::ctrl_cmd_t  cmd_o
);
  import itoa_pkg::*;

  itoa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        // hex loads the digits directly; the datapath holds them through these cycles
        cmd_o.dabble = 1'b1;
        if (status_i.conv_last) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop one leading zero digit per cycle, keep at least one
        if (status_i.top_zero && !status_i.remain_one) begin
          cmd_o.shift_digit = 1'b1;
        end else if (status_i.neg_dec) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_SIGN: begin
        cmd_o.emit_sign = 1'b1;
        out_valid_o     = 1'b1;
        if (out_ready_i) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.shift_digit = 1'b1;
          if (status_i.remain_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
